[hw/rtl/ttct_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// shared constants, codes and types of the timestamp-tagged crop table
package ttct_pkg;

    localparam int RING_DEPTH = 512;
    localparam int ADDR_W     = $clog2(RING_DEPTH);
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    typedef enum logic {
        OP_RECORD = 1'b0,
        OP_LOOKUP = 1'b1
    } t_opcode;

    localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_HEIGHT = 1'd1;

    typedef struct packed {
        logic [15:0] device_id;
        logic [63:0] timestamp;
        logic [15:0] left;
        logic [15:0] top;
        logic [15:0] wide;
        logic [15:0] tall;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic        found;
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] width;
        logic [15:0] height;
    } t_result;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_PUSH
    } t_state;

    typedef struct packed {
        logic rec_write;
        logic key_load;
        logic scan_issue;
        logic res_hit;
        logic res_miss;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic hit;
        logic scan_end;
        logic out_free;
    } t_status;

endpackage
`default_nettype wire

[hw/rtl/ttct_in_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// input item channel of the crop table
interface ttct_in_if;
    logic               valid;
    logic               ready;
    logic               opcode;
    logic        [15:0] device_id;
    logic        [63:0] timestamp;
    logic signed [15:0] crop_x;
    logic signed [15:0] crop_y;
    logic        [15:0] crop_width;
    logic        [15:0] crop_height;

    modport source (
        output valid, opcode, device_id, timestamp, crop_x, crop_y, crop_width, crop_height,
        input  ready
    );
    modport sink (
        input  valid, opcode, device_id, timestamp, crop_x, crop_y, crop_width, crop_height,
        output ready
    );
endinterface
`default_nettype wire

[hw/rtl/ttct_out_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// result channel of the crop table
interface ttct_out_if;
    logic               valid;
    logic               ready;
    logic               found;
    logic signed [15:0] out_x;
    logic signed [15:0] out_y;
    logic        [15:0] out_width;
    logic        [15:0] out_height;

    modport source (
        output valid, found, out_x, out_y, out_width, out_height,
        input  ready
    );
    modport sink (
        input  valid, found, out_x, out_y, out_width, out_height,
        output ready
    );
endinterface
`default_nettype wire

[hw/rtl/ttct_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// generic single-write, single-read ram with registered read data
module ttct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

[hw/rtl/ttct_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// controller state machine of the crop table
module ttct_ctrl import ttct_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    input  wire logic    i_in_opcode,
    output logic         o_in_ready,
    input  wire t_status i_status,
    output t_cmd         o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid && (i_in_opcode == OP_LOOKUP)) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (i_status.hit || i_status.scan_end) begin
                    n_state = ST_PUSH;
                end
            end
            ST_PUSH: begin
                if (i_status.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_in_opcode == OP_LOOKUP) begin
                        o_cmd.key_load = 1'b1;
                    end else begin
                        o_cmd.rec_write = 1'b1;
                    end
                end
            end
            ST_SCAN: begin
                priority if (i_status.hit) begin
                    o_cmd.res_hit = 1'b1;
                end else if (i_status.scan_end) begin
                    o_cmd.res_miss = 1'b1;
                end else begin
                    o_cmd.scan_issue = 1'b1;
                end
            end
            ST_PUSH: begin
                o_cmd.out_load = i_status.out_free;
            end
            default: o_cmd = '0;
        endcase
    end

endmodule
`default_nettype wire

[hw/rtl/ttct_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none
// ring store, scan compare and result registers of the crop table
module ttct_datapath import ttct_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic [15:0]           i_device_id,
    input  wire logic [63:0]           i_timestamp,
    input  wire logic signed [15:0]    i_crop_x,
    input  wire logic signed [15:0]    i_crop_y,
    input  wire logic [15:0]           i_crop_width,
    input  wire logic [15:0]           i_crop_height,
    input  wire t_cmd                  i_cmd,
    output t_status                    o_status,
    ttct_out_if.source                 o_result
);

    localparam logic [ADDR_W-1:0] LAST_ADDR  = ADDR_W'(RING_DEPTH - 1);
    localparam logic [ADDR_W:0]   DEPTH_CNT  = (ADDR_W + 1)'(RING_DEPTH);
    localparam logic [ADDR_W:0]   LAST_CNT   = (ADDR_W + 1)'(RING_DEPTH - 1);

    logic [15:0]     r_dflt_w;
    logic [15:0]     r_dflt_h;
    logic [ADDR_W-1:0] r_wp;
    logic [ADDR_W:0] r_fill;
    logic [ADDR_W:0] r_scan_idx;
    logic            r_chk_vld;
    logic            r_chk_live;
    logic            r_chk_last;
    logic [15:0]     r_key_dev;
    logic [63:0]     r_key_ts;
    t_result         r_res;
    t_result         r_out;
    logic            r_out_vld;

    t_entry w_wr_entry;
    t_entry w_rd_entry;
    t_entry w_entry;
    logic   w_issue;
    logic   w_match;

    assign w_wr_entry = '{
        device_id: i_device_id,
        timestamp: i_timestamp,
        left:      i_crop_x,
        top:       i_crop_y,
        wide:      i_crop_width,
        tall:      i_crop_height
    };

    assign w_issue = i_cmd.scan_issue && (r_scan_idx < DEPTH_CNT);

    ttct_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (i_cmd.rec_write),
        .i_waddr (r_wp),
        .i_wdata (w_wr_entry),
        .i_re    (w_issue),
        .i_raddr (r_scan_idx[ADDR_W-1:0]),
        .o_rdata (w_rd_entry)
    );

    // slots past the fill count were never written and read as zero
    assign w_entry = r_chk_live ? w_rd_entry : '0;
    assign w_match = r_chk_vld && (w_entry.device_id == r_key_dev)
                               && (w_entry.timestamp == r_key_ts);

    assign o_status.hit      = w_match;
    assign o_status.scan_end = r_chk_vld && r_chk_last;
    assign o_status.out_free = !r_out_vld || o_result.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dflt_w   <= '0;
            r_dflt_h   <= '0;
            r_wp       <= '0;
            r_fill     <= '0;
            r_scan_idx <= '0;
            r_chk_vld  <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            if (i_cfg_we && (i_cfg_idx == CFG_DEFAULT_WIDTH)) begin
                r_dflt_w <= i_cfg_data;
            end
            if (i_cfg_we && (i_cfg_idx == CFG_DEFAULT_HEIGHT)) begin
                r_dflt_h <= i_cfg_data;
            end
            if (i_cmd.rec_write) begin
                r_wp <= (r_wp == LAST_ADDR) ? '0 : r_wp + 1'b1;
                if (r_fill != DEPTH_CNT) begin
                    r_fill <= r_fill + 1'b1;
                end
            end
            if (i_cmd.key_load) begin
                r_scan_idx <= '0;
                r_chk_vld  <= 1'b0;
            end else begin
                r_chk_vld <= w_issue;
                if (w_issue) begin
                    r_scan_idx <= r_scan_idx + 1'b1;
                end
            end
            if (i_cmd.out_load) begin
                r_out_vld <= 1'b1;
            end else if (o_result.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.key_load) begin
            r_key_dev <= i_device_id;
            r_key_ts  <= i_timestamp;
        end
        if (w_issue) begin
            r_chk_live <= r_scan_idx < r_fill;
            r_chk_last <= r_scan_idx == LAST_CNT;
        end
        if (i_cmd.res_hit) begin
            r_res <= '{found: 1'b1, x: w_entry.left, y: w_entry.top,
                       width: w_entry.wide, height: w_entry.tall};
        end else if (i_cmd.res_miss) begin
            r_res <= '{found: 1'b0, x: '0, y: '0, width: r_dflt_w, height: r_dflt_h};
        end
        if (i_cmd.out_load) begin
            r_out <= r_res;
        end
    end

    assign o_result.valid      = r_out_vld;
    assign o_result.found      = r_out.found;
    assign o_result.out_x      = r_out.x;
    assign o_result.out_y      = r_out.y;
    assign o_result.out_width  = r_out.width;
    assign o_result.out_height = r_out.height;

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= DEPTH_CNT)
        else $error("fill count beyond ring depth");

    a_wp_tracks_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill < DEPTH_CNT) |-> (r_wp == r_fill[ADDR_W-1:0]))
        else $error("write pointer out of step with fill count");

    a_no_write_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.rec_write |-> !r_chk_vld)
        else $error("record write while a scan read is in flight");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !o_result.ready) |=> r_out_vld)
        else $error("pending result dropped");
`endif

endmodule
`default_nettype wire

[hw/rtl/timestamp_tagged_crop_table.sv]
`timescale 1ns / 1ps
`default_nettype none
// top level of the timestamp-tagged crop table
//
// a ring of RING_DEPTH crop records, each tagged by device id and 64-bit
// timestamp, held in one single-port-write ram. a record transaction
// (opcode 0) writes the ring at the write pointer and gives no
// result; the pointer wraps so the oldest record is overwritten. a lookup
// transaction (opcode 1) scans the ring from index 0, one entry per cycle
// through the ram's registered read port, and returns the first entry whose
// device id and timestamp both match, with found set; on a miss it returns
// x = 0, y = 0 and the default width and height registers. a lookup holds
// off new transactions from its acceptance until its result is loaded into
// the output register, whereas a record leaves the block free for the next
// transaction. slots never written read as all zero, so a lookup of
// device 0 at time 0 hits the first unwritten slot; this is tracked by a
// fill count, so there is no clearing pass after reset and the block
// accepts transactions straight away. the finished result waits in an
// output register, and record transactions are still taken while it
// waits. configuration writes (register 0 default width, register 1
// default height) take effect at once and should be made only while no
// lookup is in flight
module timestamp_tagged_crop_table import ttct_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    ttct_in_if.sink                    i_item,
    ttct_out_if.source                 o_result
);

    t_cmd    w_cmd;
    t_status w_status;

    // sequencing of record, scan and result hand-off
    ttct_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_item.valid),
        .i_in_opcode (i_item.opcode),
        .o_in_ready  (i_item.ready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    // ring store, key compare, default registers and output register
    ttct_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_device_id   (i_item.device_id),
        .i_timestamp   (i_item.timestamp),
        .i_crop_x      (i_item.crop_x),
        .i_crop_y      (i_item.crop_y),
        .i_crop_width  (i_item.crop_width),
        .i_crop_height (i_item.crop_height),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .o_result      (o_result)
    );

endmodule
`default_nettype wire

[bench/tb_timestamp_tagged_crop_table.sv]
`timescale 1ns / 1ps
// self-checking testbench of the timestamp-tagged crop table
module tb_timestamp_tagged_crop_table;
    import ttct_pkg::*;

    // generous cycle budget: every transaction a full miss scan plus the longest
    // gap on each side, several times over
    localparam int CYCLE_LIMIT  = 2_500_000;
    localparam int SETTLE_WAIT  = 8;
    localparam int POOL_SIZE    = 8;

    // one input transaction as the stimulus sees it
    typedef struct packed {
        t_opcode     op;
        logic [15:0] dev;
        logic [63:0] ts;
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] w;
        logic [15:0] h;
    } t_item;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    ttct_in_if  item_if ();
    ttct_out_if res_if ();

    timestamp_tagged_crop_table uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_item     (item_if),
        .o_result   (res_if)
    );

    // shadow copy of the crop ring and the default registers
    logic [15:0]       ring_dev  [RING_DEPTH];
    logic [63:0]       ring_time [RING_DEPTH];
    logic [15:0]       ring_left [RING_DEPTH];
    logic [15:0]       ring_top  [RING_DEPTH];
    logic [15:0]       ring_wide [RING_DEPTH];
    logic [15:0]       ring_tall [RING_DEPTH];
    logic [ADDR_W-1:0] ring_wp;
    int                ring_fill;
    logic [15:0]       dflt_width;
    logic [15:0]       dflt_height;

    // lookup answers still owed by the block, oldest first
    t_result pending_crops[$];

    // key pool so that records collide and lookups hit
    logic [15:0] dev_pool [POOL_SIZE];
    logic [63:0] ts_pool  [POOL_SIZE];

    // idling switches for the sender and the receiver
    bit tx_idle;
    bit rx_idle;

    int fail_count;
    int cycle_count;
    int n_records;
    int n_lookups;
    int n_hits;
    int n_misses;
    int n_reg_writes;

    // clock, 10 ns period
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("== FAIL ==");
            $finish;
        end
    end

    // gap length: mostly none, often short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 4);
        return $urandom_range(10, 40);
    endfunction

    // expected answer of a lookup: lowest matching index wins, else the defaults
    function automatic t_result predict_crop(logic [15:0] dev, logic [63:0] ts);
        t_result r;
        r = '{found: 1'b0, x: 16'd0, y: 16'd0, width: dflt_width, height: dflt_height};
        for (int i = 0; i < RING_DEPTH; i++) begin
            if (ring_dev[i] == dev && ring_time[i] == ts) begin
                r = '{found: 1'b1, x: ring_left[i], y: ring_top[i],
                      width: ring_wide[i], height: ring_tall[i]};
                break;
            end
        end
        return r;
    endfunction

    // a record overwrites the slot at the write pointer, which then wraps
    task automatic store_record(input t_item it);
        ring_dev[ring_wp]  = it.dev;
        ring_time[ring_wp] = it.ts;
        ring_left[ring_wp] = it.x;
        ring_top[ring_wp]  = it.y;
        ring_wide[ring_wp] = it.w;
        ring_tall[ring_wp] = it.h;
        ring_wp            = ring_wp + 1'b1;
        if (ring_fill < RING_DEPTH)
            ring_fill++;
    endtask

    function automatic t_item make_record(logic [15:0] dev, logic [63:0] ts,
                                          logic [15:0] x, logic [15:0] y,
                                          logic [15:0] w, logic [15:0] h);
        return '{op: OP_RECORD, dev: dev, ts: ts, x: x, y: y, w: w, h: h};
    endfunction

    // rectangle fields of a lookup carry noise, the block must ignore them
    function automatic t_item make_lookup(logic [15:0] dev, logic [63:0] ts);
        return '{op: OP_LOOKUP, dev: dev, ts: ts, x: 16'($urandom), y: 16'($urandom),
                 w: 16'($urandom), h: 16'($urandom)};
    endfunction

    // present one transaction after a random gap while tx_idle is set, then
    // wait for the handshake; valid stays high so back-to-back ones need no dip
    task automatic send_item(input t_item it);
        int gap;
        gap = tx_idle ? pick_gap() : 0;
        repeat (gap) begin
            @(negedge i_clk);
            item_if.valid = 1'b0;
        end
        @(negedge i_clk);
        item_if.opcode      = it.op;
        item_if.device_id   = it.dev;
        item_if.timestamp   = it.ts;
        item_if.crop_x      = it.x;
        item_if.crop_y      = it.y;
        item_if.crop_width  = it.w;
        item_if.crop_height = it.h;
        item_if.valid       = 1'b1;
        @(posedge i_clk);
        while (!item_if.ready)
            @(posedge i_clk);
        if (it.op == OP_RECORD) begin
            store_record(it);
            n_records++;
        end else begin
            pending_crops.push_back(predict_crop(it.dev, it.ts));
            n_lookups++;
        end
    endtask

    // stop sending and wait until every owed answer has come back
    task automatic wait_for_answers();
        @(negedge i_clk);
        item_if.valid = 1'b0;
        while (pending_crops.size() != 0)
            @(posedge i_clk);
    endtask

    // idle the block fully: answers drained and a trailing record retired
    task automatic settle_block();
        wait_for_answers();
        repeat (SETTLE_WAIT) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
        @(negedge i_clk);
        cfg_we   = 1'b1;
        cfg_idx  = idx;
        cfg_data = data;
        @(posedge i_clk);
        case (idx)
            CFG_DEFAULT_WIDTH:  dflt_width  = data;
            CFG_DEFAULT_HEIGHT: dflt_height = data;
            default: ;
        endcase
        n_reg_writes++;
        @(negedge i_clk);
        cfg_we = 1'b0;
    endtask

    // result side: compare each transaction with the oldest expectation
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (pending_crops.size() == 0) begin
                $error("result with no lookup outstanding: found %0b x %0d y %0d",
                       res_if.found, $signed(res_if.out_x), $signed(res_if.out_y));
                fail_count++;
            end else begin
                want = pending_crops.pop_front();
                if (want.found !== res_if.found) begin
                    $error("found expected %0b actual %0b", want.found, res_if.found);
                    fail_count++;
                end
                if (want.x !== res_if.out_x) begin
                    $error("out_x expected %0d actual %0d", $signed(want.x),
                           $signed(res_if.out_x));
                    fail_count++;
                end
                if (want.y !== res_if.out_y) begin
                    $error("out_y expected %0d actual %0d", $signed(want.y),
                           $signed(res_if.out_y));
                    fail_count++;
                end
                if (want.width !== res_if.out_width) begin
                    $error("out_width expected %0d actual %0d", want.width,
                           res_if.out_width);
                    fail_count++;
                end
                if (want.height !== res_if.out_height) begin
                    $error("out_height expected %0d actual %0d", want.height,
                           res_if.out_height);
                    fail_count++;
                end
                if (want.found)
                    n_hits++;
                else
                    n_misses++;
            end
        end
    end

    // result back-pressure: bursts of ready, random stalls while rx_idle is set
    initial begin
        int stall;
        int run;
        res_if.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            stall = rx_idle ? pick_gap() : 0;
            repeat (stall) begin
                @(negedge i_clk);
                res_if.ready = 1'b0;
            end
            run = $urandom_range(1, 8);
            repeat (run) begin
                @(negedge i_clk);
                res_if.ready = 1'b1;
            end
        end
    end

    // straight after reset every slot is zero, so device 0 at time 0 hits
    // slot 0 with an empty rectangle; near misses on either key fall back
    task automatic test_unwritten_slots();
        send_item(make_lookup(16'h0000, 64'h0));
        send_item(make_lookup(16'h0000, 64'h1));
        send_item(make_lookup(16'h0001, 64'h0));
    endtask

    // misses return the default registers, tried at their extremes
    task automatic test_default_extremes();
        settle_block();
        write_reg(CFG_DEFAULT_WIDTH, 16'hFFFF);
        write_reg(CFG_DEFAULT_HEIGHT, 16'hFFFF);
        send_item(make_lookup(16'h1234, 64'hDEAD_BEEF_0BAD_F00D));
        settle_block();
        write_reg(CFG_DEFAULT_WIDTH, 16'hFFFF);
        write_reg(CFG_DEFAULT_HEIGHT, 16'h0000);
        send_item(make_lookup(16'hFFFF, 64'h0));
    endtask

    // extreme keys and rectangles; a written zero key must shadow the
    // unwritten zero slots behind it
    task automatic test_record_extremes();
        send_item(make_record(16'hFFFF, '1, 16'h8000, 16'h7FFF, 16'hFFFF, 16'h0000));
        send_item(make_record(16'h0000, 64'h0, 16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF));
        send_item(make_lookup(16'hFFFF, '1));
        send_item(make_lookup(16'h0000, 64'h0));
    endtask

    // the lowest index wins among duplicates; one key alone never matches
    task automatic test_first_match();
        send_item(make_record(16'hA5A5, 64'h5A5A_0000_FFFF_1234, 16'd11, 16'd22,
                              16'd33, 16'd44));
        send_item(make_record(16'hA5A5, 64'h5A5A_0000_FFFF_1234, 16'd55, 16'd66,
                              16'd77, 16'd88));
        send_item(make_record(16'hA5A5, 64'h8000_0000_0000_0000, 16'hFFFF, 16'h0001,
                              16'd1, 16'd2));
        send_item(make_lookup(16'hA5A5, 64'h5A5A_0000_FFFF_1234));
        send_item(make_lookup(16'hA5A5, 64'h8000_0000_0000_0000));
        send_item(make_lookup(16'hA5A5, 64'h5A5A_0000_FFFF_1235));
        send_item(make_lookup(16'hA5A4, 64'h5A5A_0000_FFFF_1234));
    endtask

    // random traffic: records mostly from a small key pool so duplicates and
    // ring wrap-around occur, lookups mostly aimed at keys the ring holds
    task automatic test_random_traffic(input int n_items, input logic [15:0] width,
                                       input logic [15:0] height, input bit tx_gaps,
                                       input bit rx_gaps);
        t_item it;
        int    r;
        int    slot;
        settle_block();
        write_reg(CFG_DEFAULT_WIDTH, width);
        write_reg(CFG_DEFAULT_HEIGHT, height);
        tx_idle = tx_gaps;
        rx_idle = rx_gaps;
        for (int n = 0; n < n_items; n++) begin
            r = $urandom_range(0, 99);
            if (r < 50) begin
                if ($urandom_range(0, 9) < 7)
                    it = make_record(dev_pool[$urandom_range(0, POOL_SIZE - 1)],
                                     ts_pool[$urandom_range(0, POOL_SIZE - 1)],
                                     16'($urandom), 16'($urandom),
                                     16'($urandom), 16'($urandom));
                else
                    it = make_record(16'($urandom), {$urandom, $urandom},
                                     16'($urandom), 16'($urandom),
                                     16'($urandom), 16'($urandom));
            end else begin
                r = $urandom_range(0, 99);
                if (r < 50 && ring_fill > 0) begin
                    slot = $urandom_range(0, ring_fill - 1);
                    it   = make_lookup(ring_dev[slot], ring_time[slot]);
                end else if (r < 75) begin
                    it = make_lookup(dev_pool[$urandom_range(0, POOL_SIZE - 1)],
                                     ts_pool[$urandom_range(0, POOL_SIZE - 1)]);
                end else if (r < 90) begin
                    it = make_lookup(16'($urandom), {$urandom, $urandom});
                end else begin
                    it = make_lookup(16'h0000, 64'h0);
                end
            end
            send_item(it);
            // now and then hold the sender back until the block has answered all
            if ($urandom_range(0, 59) == 0)
                wait_for_answers();
        end
    endtask

    initial begin
        i_rst_n             = 1'b0;
        cfg_we              = 1'b0;
        cfg_idx             = CFG_DEFAULT_WIDTH;
        cfg_data            = 16'h0000;
        item_if.valid       = 1'b0;
        item_if.opcode      = OP_RECORD;
        item_if.device_id   = 16'h0000;
        item_if.timestamp   = 64'h0;
        item_if.crop_x      = 16'sd0;
        item_if.crop_y      = 16'sd0;
        item_if.crop_width  = 16'h0000;
        item_if.crop_height = 16'h0000;
        tx_idle             = 1'b1;
        rx_idle             = 1'b1;
        fail_count          = 0;
        cycle_count         = 0;
        n_records           = 0;
        n_lookups           = 0;
        n_hits              = 0;
        n_misses            = 0;
        n_reg_writes        = 0;

        // shadow state mirrors the ring, whose unwritten slots read as zero
        for (int i = 0; i < RING_DEPTH; i++) begin
            ring_dev[i]  = '0;
            ring_time[i] = '0;
            ring_left[i] = '0;
            ring_top[i]  = '0;
            ring_wide[i] = '0;
            ring_tall[i] = '0;
        end
        ring_wp     = '0;
        ring_fill   = 0;
        dflt_width  = '0;
        dflt_height = '0;

        // key pool with the extremes of both keys in it
        for (int i = 0; i < POOL_SIZE; i++) begin
            dev_pool[i] = 16'($urandom);
            ts_pool[i]  = {$urandom, $urandom};
        end
        dev_pool[0] = 16'h0000;
        dev_pool[1] = 16'hFFFF;
        ts_pool[0]  = 64'h0;
        ts_pool[1]  = '1;

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_unwritten_slots();
        test_default_extremes();
        test_record_extremes();
        test_first_match();

        // phases with fresh defaults; the first runs flat out on both sides
        test_random_traffic(150, 16'h0000, 16'h0000, 1'b0, 1'b0);
        test_random_traffic(225, 16'($urandom), 16'($urandom), 1'b1, 1'b1);
        test_random_traffic(225, 16'hFFFF, 16'h0000, 1'b1, 1'b1);
        test_random_traffic(225, 16'h0000, 16'hFFFF, 1'b1, 1'b0);
        test_random_traffic(225, 16'($urandom), 16'($urandom), 1'b0, 1'b1);

        // drain, then give a full scan's worth of cycles for stray results
        wait_for_answers();
        repeat (RING_DEPTH + SETTLE_WAIT) @(posedge i_clk);

        $display("covered %0d record and %0d lookup transactions, %0d register writes",
                 n_records, n_lookups, n_reg_writes);
        $display("lookups answered: %0d hits, %0d misses, %0d mismatches",
                 n_hits, n_misses, fail_count);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
